/* hw/rtl/tlb_lru_address_translator_assert.svh */
// assertion macros shared by the translator rtl
// depends on: a clock named clk and a synchronous active-high reset named rst in the using module
`ifndef TLB_LRU_ADDRESS_TRANSLATOR_ASSERT_SVH
`define TLB_LRU_ADDRESS_TRANSLATOR_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define TLAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlat: same-cycle check failed");

// next-cycle implication, quiet while in reset
`define TLAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlat: next-cycle check failed");

`endif

/* hw/rtl/tlat_pkg.sv */
// shared types and constants for the tlb address translator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlat_pkg;

  localparam int ADDR_W          = 16;
  localparam int PAGE_BYTES      = 256;
  localparam int OFFSET_W        = $clog2(PAGE_BYTES);
  localparam int PAGE_W          = ADDR_W - OFFSET_W;
  localparam int PAGE_COUNT      = 256;
  localparam int FRAME_W         = 8;
  localparam int NFF_W           = $clog2(PAGE_COUNT) + 1;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  // command from front to back: one per accepted beat
  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic                hit;
    logic [FRAME_W-1:0]  frame;
  } cmd_t;

  // refill from back to front after a miss
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } refill_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/tlat_front.sv */
// front end: accepts addresses, does the associative tlb lookup and lru bookkeeping
// depends on: tlat_pkg, tlb_lru_address_translator_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "tlb_lru_address_translator_assert.svh"

module tlat_front #(
  parameter int TLB_ENTRIES = tlat_pkg::TLB_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tlat_pkg::ADDR_W-1:0]   virtual_address,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output tlat_pkg::cmd_t                     push_data,
  input  wire tlat_pkg::refill_t             refill
);

  localparam int RANK_W = $clog2(TLB_ENTRIES);

  logic                          pend_valid;
  logic [tlat_pkg::ADDR_W-1:0]   pend_addr;
  logic                          wait_refill;
  logic [tlat_pkg::PAGE_W-1:0]   miss_page;

  logic [tlat_pkg::PAGE_W-1:0]   tag   [TLB_ENTRIES];
  logic [tlat_pkg::FRAME_W-1:0]  frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]        entry_valid;
  logic [RANK_W-1:0]             rank  [TLB_ENTRIES];

  logic [tlat_pkg::PAGE_W-1:0]   page;
  logic [TLB_ENTRIES-1:0]        hit_vec;
  logic                          hit_any;
  logic [RANK_W-1:0]             hit_idx;
  logic                          inv_any;
  logic [RANK_W-1:0]             inv_idx;
  logic [RANK_W-1:0]             lru_idx;
  logic [RANK_W-1:0]             victim;
  logic                          issue;
  logic                          accept;
  logic                          touch_en;
  logic [RANK_W-1:0]             touch_idx;
  logic [RANK_W-1:0]             touch_rank;

  assign page = pend_addr[tlat_pkg::ADDR_W-1 -: tlat_pkg::PAGE_W];

  // parallel tag compare, lowest matching entry wins
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = entry_valid[i] && (tag[i] == page);
      if (hit_vec[i]) begin
        hit_idx = RANK_W'(i);
      end
    end
  end

  assign hit_any = |hit_vec;

  // victim: lowest invalid entry, else the entry holding the oldest rank
  always_comb begin
    inv_idx = '0;
    lru_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        inv_idx = RANK_W'(i);
      end
      if (rank[i] == RANK_W'(TLB_ENTRIES - 1)) begin
        lru_idx = RANK_W'(i);
      end
    end
  end

  assign inv_any = ~&entry_valid;
  assign victim  = inv_any ? inv_idx : lru_idx;

  // handshakes: a hit frees the slot in the same cycle, a miss blocks until refill
  assign push_valid       = pend_valid;
  assign push_data.page   = page;
  assign push_data.offset = pend_addr[tlat_pkg::OFFSET_W-1:0];
  assign push_data.hit    = hit_any;
  assign push_data.frame  = frame[hit_idx];

  assign issue    = pend_valid && push_ready;
  assign in_stall = wait_refill || (pend_valid && !(issue && hit_any));
  assign accept   = in_valid && !in_stall;

  // entry made most recent: hit at issue, or victim at refill
  always_comb begin
    touch_en  = 1'b0;
    touch_idx = hit_idx;
    if (issue && hit_any) begin
      touch_en = 1'b1;
    end else if (refill.valid) begin
      touch_en  = 1'b1;
      touch_idx = victim;
    end
  end

  assign touch_rank = rank[touch_idx];

  // control state, valid bits and recency ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      wait_refill <= 1'b0;
      entry_valid <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank[i] <= RANK_W'(i);
      end
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (issue) begin
        pend_valid <= 1'b0;
      end
      if (issue && !hit_any) begin
        wait_refill <= 1'b1;
      end else if (refill.valid) begin
        wait_refill <= 1'b0;
      end
      if (refill.valid) begin
        entry_valid[victim] <= 1'b1;
      end
      if (touch_en) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (rank[i] < touch_rank) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        rank[touch_idx] <= '0;
      end
    end
  end

  // payload: held address, missed page, tags and frames
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_addr <= virtual_address;
    end
    if (issue && !hit_any) begin
      miss_page <= page;
    end
    if (refill.valid) begin
      tag[victim]   <= miss_page;
      frame[victim] <= refill.frame;
    end
  end

  // checks
  `TLAT_ASSERT_NOW(a_refill_when_waiting, refill.valid, wait_refill && !pend_valid)
  `TLAT_ASSERT_NOW(a_single_match, pend_valid, $onehot0(hit_vec))
  `TLAT_ASSERT_NEXT(a_miss_blocks, issue && !hit_any, wait_refill && in_stall)

endmodule

`default_nettype wire

/* hw/rtl/tlat_queue.sv */
// short command queue between the front and back ends
// depends on: tlat_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlat_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire tlat_pkg::cmd_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output tlat_pkg::cmd_t       pop_data
);

  localparam int PTR_W = $clog2(tlat_pkg::QUEUE_DEPTH);

  tlat_pkg::cmd_t   slot [tlat_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != (PTR_W + 1)'(tlat_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tlat_back.sv */
// back end: page map memory, demand paging and the result register
// depends on: tlat_pkg, tlb_lru_address_translator_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "tlb_lru_address_translator_assert.svh"

module tlat_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire tlat_pkg::cmd_t                pop_data,
  output tlat_pkg::refill_t                  refill,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tlat_pkg::ADDR_W-1:0]        physical_address,
  output logic                               tlb_hit,
  output logic                               page_fault
);

  tlat_pkg::back_state_t              state;
  tlat_pkg::back_state_t              state_next;
  tlat_pkg::cmd_t                     cur;
  logic [tlat_pkg::FRAME_W-1:0]       map_mem [tlat_pkg::PAGE_COUNT];
  logic [tlat_pkg::FRAME_W-1:0]       rd_data;
  logic [tlat_pkg::PAGE_COUNT-1:0]    mapped;
  logic [tlat_pkg::NFF_W-1:0]         nff;

  logic                               out_free;
  logic                               cmd_load;
  logic                               load_out;
  logic                               fault;
  logic                               map_we;
  logic [tlat_pkg::FRAME_W-1:0]       miss_frame;
  logic [tlat_pkg::FRAME_W-1:0]       frame_next;
  logic [tlat_pkg::OFFSET_W-1:0]      offset_next;
  logic                               hit_next;
  logic                               fault_next;

  assign out_free   = !out_valid || !out_stall;
  assign fault      = !mapped[cur.page];
  assign miss_frame = fault ? nff[tlat_pkg::FRAME_W-1:0] : rd_data;

  // next state and datapath controls
  always_comb begin
    state_next   = state;
    pop_ready    = 1'b0;
    cmd_load     = 1'b0;
    load_out     = 1'b0;
    map_we       = 1'b0;
    refill.valid = 1'b0;
    refill.frame = miss_frame;
    frame_next   = pop_data.frame;
    offset_next  = pop_data.offset;
    hit_next     = 1'b1;
    fault_next   = 1'b0;
    case (state)
      tlat_pkg::BK_IDLE: begin
        if (pop_valid && out_free) begin
          pop_ready = 1'b1;
          if (pop_data.hit) begin
            load_out = 1'b1;
          end else begin
            cmd_load   = 1'b1;
            state_next = tlat_pkg::BK_READ;
          end
        end
      end
      tlat_pkg::BK_READ: begin
        frame_next  = miss_frame;
        offset_next = cur.offset;
        hit_next    = 1'b0;
        fault_next  = fault;
        if (out_free) begin
          load_out     = 1'b1;
          map_we       = fault;
          refill.valid = 1'b1;
          state_next   = tlat_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = tlat_pkg::BK_IDLE;
      end
    endcase
  end

  // state, map valid bits, free frame counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlat_pkg::BK_IDLE;
      mapped    <= '0;
      nff       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (map_we) begin
        mapped[cur.page] <= 1'b1;
        if (nff < tlat_pkg::NFF_W'(tlat_pkg::PAGE_COUNT)) begin
          nff <= nff + 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // page map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[cur.page] <= miss_frame;
    end
    if (state == tlat_pkg::BK_IDLE) begin
      rd_data <= map_mem[pop_data.page];
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cur <= pop_data;
    end
    if (load_out) begin
      physical_address <= {frame_next, offset_next};
      tlb_hit          <= hit_next;
      page_fault       <= fault_next;
    end
  end

  // checks
  `TLAT_ASSERT_NOW(a_read_only_on_miss, state == tlat_pkg::BK_READ, !cur.hit)
  `TLAT_ASSERT_NOW(a_frames_bounded, 1'b1, nff <= tlat_pkg::NFF_W'(tlat_pkg::PAGE_COUNT))
  `TLAT_ASSERT_NOW(a_one_kind, out_valid, !(tlb_hit && page_fault))

endmodule

`default_nettype wire

/* hw/rtl/tlb_lru_address_translator.sv */
// channel   dir  beat fields                                 handshake
// input     in   virtual_address                             in_valid / in_stall
// output    out  physical_address, tlb_hit, page_fault       out_valid / out_stall
//
// a tlb hit frees the front on issue; hits stream one beat per cycle unless stalled.
// a miss holds the front until the back has read the page map and refilled the tlb;
// the refill loop runs through the page map read port. reset clears valid bits and
// counters at once, no clearing pass.
// out_stall backs up through the result register and the two-entry queue to in_stall.
// depends on: tlat_pkg, tlat_front, tlat_queue, tlat_back
`timescale 1ns / 1ps
`default_nettype none

module tlb_lru_address_translator #(
  parameter int TLB_ENTRIES = tlat_pkg::TLB_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tlat_pkg::ADDR_W-1:0]   virtual_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tlat_pkg::ADDR_W-1:0]        physical_address,
  output logic                               tlb_hit,
  output logic                               page_fault
);

  logic              push_valid;
  logic              push_ready;
  tlat_pkg::cmd_t    push_data;
  logic              pop_valid;
  logic              pop_ready;
  tlat_pkg::cmd_t    pop_data;
  tlat_pkg::refill_t refill;

  // lookup and replacement
  tlat_front #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .virtual_address (virtual_address),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data),
    .refill          (refill)
  );

  // decoupling queue
  tlat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // page map and results
  tlat_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .refill           (refill),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault)
  );

endmodule

`default_nettype wire
